// ----- src/minv_pkg.sv -----
// Package for the 3x3 fixed-point matrix inverse: default sizes and shared types.
// Depends on nothing; used by every module of the block.
package minv_pkg;
   localparam int FracBitsDefault   = 16;
   localparam int EntryWidthDefault = 24;

   typedef struct packed {
      logic valid;
      logic singular;
   } ctl_type;
endpackage

// ----- src/minv_divider.sv -----
// Pipelined restoring divider for one inverse entry, with sign fixup and saturation.
// Depends on minv_pkg; one quotient bit per stage, every stage registered.
module minv_divider #(
   parameter int NUM_WIDTH = 80,
   parameter int DEN_WIDTH = 76,
   parameter int OUT_WIDTH = 24,
   parameter int QBITS     = 26
) (
   input  logic                 clock,
   input  logic [NUM_WIDTH-1:0] num_mag,
   input  logic [DEN_WIDTH-1:0] den_mag,
   input  logic                 neg,
   output logic [OUT_WIDTH-1:0] quot,
   output logic                 sat
);
   import minv_pkg::*;

   localparam int RW = DEN_WIDTH + 1;
   localparam int CW = (NUM_WIDTH > DEN_WIDTH) ? NUM_WIDTH : DEN_WIDTH;

   logic [NUM_WIDTH-1:0] n_ff [QBITS+1];
   logic [RW-1:0]        r_ff [QBITS+1];
   logic [DEN_WIDTH-1:0] d_ff [QBITS+1];
   logic [QBITS-1:0]     q_ff [QBITS+1];
   logic                 s_ff [QBITS+1];
   logic                 hi_ff [QBITS+1];

   // Stage 0 reduces the top numerator bits that no quotient bit covers; any
   // quotient bit there forces saturation. Quotient bits above QBITS are
   // detected by comparing those upper bits against the divisor.
   logic [NUM_WIDTH-1:0] top_in;
   assign top_in = num_mag >> QBITS;

   always_ff @(posedge clock) begin
      n_ff[0]  <= num_mag;
      d_ff[0]  <= den_mag;
      s_ff[0]  <= neg;
      q_ff[0]  <= '0;
      hi_ff[0] <= (CW'(top_in) >= CW'(den_mag));
      r_ff[0]  <= RW'(top_in);
   end

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      assign trial = {r_ff[k][RW-2:0], n_ff[k][QBITS-1-k]};
      assign rem_in = (trial >= {1'b0, d_ff[k]}) ? trial - {1'b0, d_ff[k]} : trial;
      always_ff @(posedge clock) begin
         n_ff[k+1]  <= n_ff[k];
         d_ff[k+1]  <= d_ff[k];
         s_ff[k+1]  <= s_ff[k];
         hi_ff[k+1] <= hi_ff[k];
         r_ff[k+1]  <= rem_in;
         q_ff[k+1]  <= {q_ff[k][QBITS-2:0], trial >= {1'b0, d_ff[k]}};
      end
   end

   logic [QBITS-1:0] q_last;
   logic [QBITS-1:0] limit;
   logic             over;
   assign q_last = q_ff[QBITS];
   assign limit  = s_ff[QBITS] ? QBITS'(1) << (OUT_WIDTH-1)
                               : (QBITS'(1) << (OUT_WIDTH-1)) - QBITS'(1);
   assign over   = hi_ff[QBITS] || (q_last > limit);

   logic [QBITS-1:0] mag;
   assign mag = over ? limit : q_last;

   always_ff @(posedge clock) begin
      quot <= s_ff[QBITS] ? OUT_WIDTH'(-mag) : OUT_WIDTH'(mag);
      sat  <= over;
   end
endmodule

// ----- src/minv_adjugate.sv -----
// Cofactor and determinant stages: products, cofactors, row products, determinant.
// Depends on minv_pkg; five register stages, with multipliers only in the product and row-product stages.
module minv_adjugate #(
   parameter int EW = 24
) (
   input  logic                   clock,
   input  logic signed [EW-1:0]   m [9],
   output logic signed [2*EW:0]   adj [9],
   output logic signed [3*EW+2:0] det
);
   import minv_pkg::*;

   localparam int PW = 2 * EW;
   localparam int AW = 2 * EW + 1;
   localparam int DW = 3 * EW + 3;

   logic signed [EW-1:0] m_ff [9];
   logic signed [PW-1:0] pa_ff [9];
   logic signed [PW-1:0] pb_ff [9];
   logic signed [EW-1:0] m2_ff [3];
   logic signed [AW-1:0] adj_ff [9];
   logic signed [EW-1:0] m3_ff [3];
   logic signed [AW+EW-1:0] rp_ff [3];
   logic signed [AW-1:0] adj2_ff [9];
   logic signed [AW-1:0] adj3_ff [9];
   logic signed [DW-1:0] det_ff;

   localparam int IA [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int IB [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int IC [9] = '{5, 8, 2, 3, 6, 0, 6, 0, 3};
   localparam int ID [9] = '{7, 1, 4, 8, 2, 5, 4, 7, 1};

   always_ff @(posedge clock) begin
      m_ff <= m;
      for (int k = 0; k < 9; k++) begin
         pa_ff[k] <= m_ff[IA[k]] * m_ff[IB[k]];
         pb_ff[k] <= m_ff[IC[k]] * m_ff[ID[k]];
      end
      for (int k = 0; k < 3; k++) m2_ff[k] <= m_ff[k];
      for (int k = 0; k < 9; k++) adj_ff[k] <= AW'(pa_ff[k]) - AW'(pb_ff[k]);
      m3_ff <= m2_ff;
      for (int k = 0; k < 3; k++) rp_ff[k] <= m3_ff[k] * adj_ff[3*k];
      adj2_ff <= adj_ff;
      adj3_ff <= adj2_ff;
      det_ff <= DW'(rp_ff[0]) + DW'(rp_ff[1]) + DW'(rp_ff[2]);
   end

   assign adj = adj3_ff;
   assign det = det_ff;
endmodule

// ----- src/matrix_inverse_3x3.sv -----
// Pipeline: 5 cofactor and determinant stages, one sign stage, then a divider pipeline
// of ENTRY_WIDTH + 3 stages.
// Throughput: one item per cycle; busy is always low. The receiver cannot stall.
// Reset clears only the control bits (valid and singular) that travel with the items.
// Depends on minv_pkg, minv_adjugate and minv_divider.
module matrix_inverse_3x3 #(
   parameter int FRAC_BITS   = minv_pkg::FracBitsDefault,
   parameter int ENTRY_WIDTH = minv_pkg::EntryWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r0c0,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r0c1,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r0c2,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r1c0,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r1c1,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r1c2,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r2c0,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r2c1,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_r2c2,
   output logic                          rsp_strobe,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r0c0,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r0c1,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r0c2,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r1c0,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r1c1,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r1c2,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r2c0,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r2c1,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv_r2c2,
   output logic                          rsp_singular,
   output logic                          rsp_saturated
);
   import minv_pkg::*;

   localparam int EW      = ENTRY_WIDTH;
   localparam int AW      = 2 * EW + 1;
   localparam int DW      = 3 * EW + 3;
   localparam int NW      = AW + 2 * FRAC_BITS;
   localparam int QBITS   = EW + 1;
   localparam int LAT     = 8 + QBITS;
   localparam int SING_AT = 6;

   logic signed [EW-1:0] m [9];
   logic signed [AW-1:0] adj [9];
   logic signed [DW-1:0] det;

   assign busy = 1'b0;
   assign m = '{req_entry_r0c0, req_entry_r0c1, req_entry_r0c2,
                req_entry_r1c0, req_entry_r1c1, req_entry_r1c2,
                req_entry_r2c0, req_entry_r2c1, req_entry_r2c2};

   minv_adjugate #(.EW(EW)) u_adj (.clock(clock), .m(m), .adj(adj), .det(det));

   // Sign stage: magnitudes and quotient signs for the divider, and the zero-determinant flag.
   logic [NW-1:0]   num_ff [9];
   logic [DW-1:0]   den_ff;
   logic            neg_ff [9];
   logic            zero_ff;
   logic [DW-1:0]   det_mag;
   assign det_mag = det[DW-1] ? DW'(-det) : DW'(det);

   always_ff @(posedge clock) begin
      den_ff  <= det_mag;
      zero_ff <= (det == '0);
      for (int k = 0; k < 9; k++) begin
         num_ff[k] <= NW'(adj[k][AW-1] ? AW'(-adj[k]) : AW'(adj[k])) << (2 * FRAC_BITS);
         neg_ff[k] <= adj[k][AW-1] ^ det[DW-1];
      end
   end

   logic [EW-1:0] q [9];
   logic          s [9];
   for (genvar k = 0; k < 9; k++) begin : g_div
      minv_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(DW), .OUT_WIDTH(EW), .QBITS(QBITS)) u_div (
         .clock(clock), .num_mag(num_ff[k]), .den_mag(den_ff), .neg(neg_ff[k]),
         .quot(q[k]), .sat(s[k]));
   end

   ctl_type ctl_ff [LAT];
   ctl_type ctl_in;
   assign ctl_in = '{valid: start, singular: 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) ctl_ff[k] <= '0;
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < LAT; k++) begin
            if (k == SING_AT) begin
               ctl_ff[k] <= '{valid: ctl_ff[k-1].valid,
                              singular: zero_ff & ctl_ff[k-1].valid};
            end else begin
               ctl_ff[k] <= ctl_ff[k-1];
            end
         end
      end
   end

   logic sing;
   logic any_sat;
   assign sing    = ctl_ff[LAT-1].singular;
   assign any_sat = s[0] | s[1] | s[2] | s[3] | s[4] | s[5] | s[6] | s[7] | s[8];

   assign rsp_strobe    = ctl_ff[LAT-1].valid;
   assign rsp_singular  = sing;
   assign rsp_saturated = sing ? 1'b0 : any_sat;
   assign rsp_inv_r0c0  = sing ? '0 : q[0];
   assign rsp_inv_r0c1  = sing ? '0 : q[1];
   assign rsp_inv_r0c2  = sing ? '0 : q[2];
   assign rsp_inv_r1c0  = sing ? '0 : q[3];
   assign rsp_inv_r1c1  = sing ? '0 : q[4];
   assign rsp_inv_r1c2  = sing ? '0 : q[5];
   assign rsp_inv_r2c0  = sing ? '0 : q[6];
   assign rsp_inv_r2c1  = sing ? '0 : q[7];
   assign rsp_inv_r2c2  = sing ? '0 : q[8];

   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy must stay low");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(LAT) rsp_strobe)
      else $error("an item was lost in the pipeline");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_singular |-> !rsp_saturated && rsp_inv_r1c1 == '0)
      else $error("singular result carries data");
endmodule
